[rtl/tdc_pkg.sv]
// shared types and constants of the tick divider with countdowns
// no dependencies; used by the top level and its checker
`default_nettype none

package tdc_pkg;

    // default sizing of the block
    localparam int DEF_NUM_MODES        = 5;
    localparam int DEF_TICKS_PER_SECOND = 1000;

    // fixed field widths
    localparam int CNT_W  = 32;
    localparam int EV_W   = 6;
    localparam int SEC_W  = 6;
    localparam int MS_W   = 10;
    localparam int PM_W   = 3;
    localparam int TGT_W  = 3;

    // bit positions in the events field
    localparam int EV_10MS  = 0;
    localparam int EV_100MS = 1;
    localparam int EV_HALF  = 2;
    localparam int EV_1S    = 3;
    localparam int EV_1MIN  = 4;
    localparam int EV_END   = 5;

    // item modes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // load targets
    localparam logic [TGT_W-1:0] TGT_END     = 3'd0;
    localparam logic [TGT_W-1:0] TGT_WAIT    = 3'd1;
    localparam logic [TGT_W-1:0] TGT_RESERVE = 3'd2;
    localparam logic [TGT_W-1:0] TGT_FINISH  = 3'd3;
    localparam logic [TGT_W-1:0] TGT_TEST    = 3'd4;
    localparam logic [TGT_W-1:0] TGT_TOTAL   = 3'd5;
    localparam logic [TGT_W-1:0] TGT_CLR_END = 3'd6;

    // last second of a minute
    localparam logic [SEC_W-1:0] SEC_LAST = 6'd59;

    // one result item
    typedef struct packed {
        logic [EV_W-1:0]  events;
        logic             end_reached;
        logic [CNT_W-1:0] total_count;
        logic [CNT_W-1:0] end_count;
        logic [CNT_W-1:0] wait_count;
        logic [CNT_W-1:0] reserve_count;
        logic [CNT_W-1:0] finish_count;
        logic [CNT_W-1:0] test_count;
        logic [SEC_W-1:0] second_count;
    } t_result;

endpackage

`default_nettype wire

[rtl/tick_divider_with_countdowns_unit.sv]
// millisecond tick divider with gated 10 ms countdowns and counter loads
// depends on tdc_pkg
// each accepted item's result is registered in the result or skid register
// one item per cycle while o_stall is low; counters update in a single pass
// a two-entry output stage (result register plus skid register) takes one
// more input item while the output is stalled
// reset (synchronous, active low) clears all counters, the end flag and valids
`default_nettype none

module tick_divider_with_countdowns_unit #(
    parameter int NUM_MODES        = tdc_pkg::DEF_NUM_MODES,
    parameter int TICKS_PER_SECOND = tdc_pkg::DEF_TICKS_PER_SECOND
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input channel
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_mode,
    input  wire logic                     i_running,
    input  wire logic                     i_test_active,
    input  wire logic                     i_process_wait,
    input  wire logic                     i_pump_on,
    input  wire logic                     i_finish_control,
    input  wire logic [tdc_pkg::PM_W-1:0]  i_process_mode,
    input  wire logic [tdc_pkg::TGT_W-1:0] i_target,
    input  wire logic [tdc_pkg::CNT_W-1:0] i_value,
    // output channel
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [tdc_pkg::EV_W-1:0]      o_events,
    output logic                          o_end_reached,
    output logic [tdc_pkg::CNT_W-1:0]     o_total_count,
    output logic [tdc_pkg::CNT_W-1:0]     o_end_count,
    output logic [tdc_pkg::CNT_W-1:0]     o_wait_count,
    output logic [tdc_pkg::CNT_W-1:0]     o_reserve_count,
    output logic [tdc_pkg::CNT_W-1:0]     o_finish_count,
    output logic [tdc_pkg::CNT_W-1:0]     o_test_count,
    output logic [tdc_pkg::SEC_W-1:0]     o_second_count
);

    import tdc_pkg::*;

    localparam int MW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam logic [MS_W-1:0] MS_WRAP = MS_W'(TICKS_PER_SECOND);
    localparam logic [MS_W-1:0] MS_HALF = MS_W'(TICKS_PER_SECOND / 2);
    localparam logic [3:0] MOD10_LAST  = 4'd9;
    localparam logic [6:0] MOD100_LAST = 7'd99;

    // saturating decrement
    function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
        return (v != '0) ? v - CNT_W'(1) : '0;
    endfunction

    // counter state
    logic [MS_W-1:0]  r_milli, n_milli;
    logic [3:0]       r_mod10, n_mod10;
    logic [6:0]       r_mod100, n_mod100;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_end, n_end;
    logic             r_end_flag, n_end_flag;
    logic [CNT_W-1:0] r_wait [NUM_MODES];
    logic [CNT_W-1:0] n_wait [NUM_MODES];
    logic [CNT_W-1:0] r_reserve, n_reserve;
    logic [CNT_W-1:0] r_finish, n_finish;
    logic [CNT_W-1:0] r_test, n_test;

    // output stage
    t_result r_out, r_skid, res;
    logic    r_out_valid, r_skid_valid;

    logic accept_in, take_out;
    logic pm_ok;
    logic [MW-1:0] wait_idx;
    logic [MS_W-1:0] ms_inc;
    logic fire10, fire100, ms_wrap;
    logic run_dec, test_dec;
    logic [1:0] end_dec;
    logic [CNT_W-1:0] end_after_run;
    logic [EV_W-1:0] ev;

    assign accept_in = i_valid && !r_skid_valid;
    assign take_out  = r_out_valid && !i_stall;
    assign o_stall   = r_skid_valid;

    assign pm_ok    = int'(i_process_mode) < NUM_MODES;
    assign wait_idx = MW'(i_process_mode);

    // tick divider helpers
    assign ms_inc  = r_milli + MS_W'(1);
    assign ms_wrap = ms_inc >= MS_WRAP;
    assign fire10  = r_mod10 == MOD10_LAST;
    assign fire100 = r_mod100 == MOD100_LAST;

    // next state and result for one item
    always_comb begin
        n_milli    = r_milli;
        n_mod10    = r_mod10;
        n_mod100   = r_mod100;
        n_sec      = r_sec;
        n_total    = r_total;
        n_end      = r_end;
        n_end_flag = r_end_flag;
        n_wait     = r_wait;
        n_reserve  = r_reserve;
        n_finish   = r_finish;
        n_test     = r_test;
        ev         = '0;
        run_dec    = 1'b0;
        test_dec   = 1'b0;
        end_dec    = 2'd0;
        end_after_run = r_end;

        if (i_mode == MODE_LOAD) begin
            case (i_target)
                TGT_END:     n_end = i_value;
                TGT_WAIT:    if (pm_ok) n_wait[wait_idx] = i_value;
                TGT_RESERVE: n_reserve = i_value;
                TGT_FINISH:  n_finish = i_value;
                TGT_TEST:    n_test = i_value;
                TGT_TOTAL:   n_total = i_value;
                TGT_CLR_END: n_end_flag = 1'b0;
                default:     ;
            endcase
        end else begin
            // millisecond count and its decimal phases
            n_milli  = ms_inc;
            n_mod10  = fire10 ? 4'd0 : r_mod10 + 4'd1;
            n_mod100 = fire100 ? 7'd0 : r_mod100 + 7'd1;

            // 10 ms countdowns; running path first, test path sees its flag
            if (fire10) begin
                if (i_running) begin
                    ev[EV_10MS] = 1'b1;
                    n_total = r_total + CNT_W'(1);
                    if (!r_end_flag) begin
                        run_dec = 1'b1;
                        if (pm_ok) n_wait[wait_idx] = dec_sat(r_wait[wait_idx]);
                        n_reserve = dec_sat(r_reserve);
                        if (!i_process_wait && i_pump_on && i_finish_control)
                            n_finish = dec_sat(r_finish);
                    end
                end
                end_after_run = run_dec ? r_end - CNT_W'(1) : r_end;
                if (run_dec && end_after_run == '0) begin
                    n_end_flag = 1'b1;
                    ev[EV_END] = 1'b1;
                end
                if (i_test_active && !n_end_flag) begin
                    test_dec = 1'b1;
                    n_test = dec_sat(r_test);
                end
                end_dec = {1'b0, run_dec} + {1'b0, test_dec};
                n_end = r_end - CNT_W'(end_dec);
                if (test_dec && n_end == '0) begin
                    n_end_flag = 1'b1;
                    ev[EV_END] = 1'b1;
                end
            end

            if (fire100) ev[EV_100MS] = 1'b1;
            if (ms_inc == MS_HALF) ev[EV_HALF] = 1'b1;

            // second and minute wrap
            if (ms_wrap) begin
                n_milli  = '0;
                n_mod10  = 4'd0;
                n_mod100 = 7'd0;
                ev[EV_1S]   = 1'b1;
                ev[EV_HALF] = 1'b1;
                if (r_sec >= SEC_LAST) begin
                    ev[EV_1MIN] = 1'b1;
                    n_sec = '0;
                end else begin
                    n_sec = r_sec + SEC_W'(1);
                end
            end
        end

        res.events        = ev;
        res.end_reached   = n_end_flag;
        res.total_count   = n_total;
        res.end_count     = n_end;
        res.wait_count    = pm_ok ? n_wait[wait_idx] : '0;
        res.reserve_count = n_reserve;
        res.finish_count  = n_finish;
        res.test_count    = n_test;
        res.second_count  = n_sec;
    end

    // counter registers, updated once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_milli    <= '0;
            r_mod10    <= '0;
            r_mod100   <= '0;
            r_sec      <= '0;
            r_total    <= '0;
            r_end      <= '0;
            r_end_flag <= 1'b0;
            r_reserve  <= '0;
            r_finish   <= '0;
            r_test     <= '0;
            for (int k = 0; k < NUM_MODES; k++) r_wait[k] <= '0;
        end else if (accept_in) begin
            r_milli    <= n_milli;
            r_mod10    <= n_mod10;
            r_mod100   <= n_mod100;
            r_sec      <= n_sec;
            r_total    <= n_total;
            r_end      <= n_end;
            r_end_flag <= n_end_flag;
            r_reserve  <= n_reserve;
            r_finish   <= n_finish;
            r_test     <= n_test;
            r_wait     <= n_wait;
        end
    end

    // output valids: result register with a skid register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take_out || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept_in;
            end
        end else if (accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output payloads
    always_ff @(posedge i_clk) begin
        if (take_out || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept_in) begin
                r_out <= res;
            end
        end else if (accept_in) begin
            r_skid <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_events        = r_out.events;
    assign o_end_reached   = r_out.end_reached;
    assign o_total_count   = r_out.total_count;
    assign o_end_count     = r_out.end_count;
    assign o_wait_count    = r_out.wait_count;
    assign o_reserve_count = r_out.reserve_count;
    assign o_finish_count  = r_out.finish_count;
    assign o_test_count    = r_out.test_count;
    assign o_second_count  = r_out.second_count;

endmodule

`default_nettype wire

[rtl/tdc_checker.sv]
// port-level checks of the tick divider with countdowns
// depends on tdc_pkg; bound to tick_divider_with_countdowns_unit below
`default_nettype none

module tdc_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_valid,
    input wire logic                     i_stall,
    input wire logic [tdc_pkg::EV_W-1:0]  o_events,
    input wire logic                     o_end_reached,
    input wire logic [tdc_pkg::CNT_W-1:0] o_total_count,
    input wire logic [tdc_pkg::CNT_W-1:0] o_end_count
);

    import tdc_pkg::*;

    // a stalled result item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_total_count) && $stable(o_events))
        else $error("stalled result item changed");

    // a minute event always comes with a second event
    a_min_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_events[EV_1MIN] |-> o_events[EV_1S])
        else $error("minute event without second event");

    // a second event always comes with a half-second event
    a_sec_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_events[EV_1S] |-> o_events[EV_HALF])
        else $error("second event without half-second event");

    // the end event sets the sticky end flag in the same item
    a_end_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_events[EV_END] |-> o_end_reached && (o_end_count == '0))
        else $error("end event without end flag");

endmodule

bind tick_divider_with_countdowns_unit tdc_checker u_tdc_checker (.*);

`default_nettype wire
